### design/mpm_pkg.sv
`timescale 1ns / 1ps
// Shared constants, codes and handshake structs for the mirror point matcher.
// Used by mpm_ctrl, mpm_datapath and mirror_point_matcher; depends on nothing.
package mpm_pkg;

  localparam int MAX_POINTS_DEF = 1024;
  localparam int INDEX_SPAN     = 1024;
  localparam int IDX_W          = 10;
  localparam int CNT_W          = 11;
  localparam int COORD_W        = 32;
  localparam int TOL_W          = 31;
  localparam int MODE_W         = 2;
  localparam int CFG_IDX_W      = 2;
  localparam int CFG_W          = 31;

  localparam logic [CFG_IDX_W-1:0] REG_REFLECT_MODE    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MATCH_TOLERANCE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_POINT_COUNT     = 2'd2;

  localparam logic [MODE_W-1:0] MODE_X    = 2'd0;
  localparam logic [MODE_W-1:0] MODE_Y    = 2'd1;
  localparam logic [MODE_W-1:0] MODE_BOTH = 2'd2;

  localparam logic CMD_LOAD   = 1'b0;
  localparam logic CMD_SEARCH = 1'b1;

  localparam logic [TOL_W-1:0]  TOL_RESET   = 31'd10;
  localparam logic [CNT_W-1:0]  COUNT_RESET = 11'd1024;

  typedef struct packed {
    logic ram_we;
    logic rd_src;
    logic start;
    logic latch_src;
    logic issue;
    logic set_hit;
    logic flush;
    logic out_load;
  } mpm_cmd_t;

  typedef struct packed {
    logic idx_ok;
    logic limit_zero;
    logic issue_more;
    logic pipe_busy;
    logic hit;
  } mpm_status_t;

endpackage

### design/mirror_point_matcher.sv
`timescale 1ns / 1ps
// Top level of the mirror point matcher: joins controller and datapath.
// Depends on mpm_pkg, mpm_ctrl, mpm_datapath and mpm_ram.
//
//   Channel   Handshake             Beat contents
//   input     in_valid / in_ready   cmd, point_index, x_coord, y_coord
//   output    out_valid / out_ready source_index, mirror_index, found
//   config    cfg_valid / cfg_ready cfg_index, cfg_data
//
// A load beat writes the store only for an in-range index. A search reads the
// source point, then scans one entry per cycle (the single store read port sets
// this rate) through the store read and difference registers to the first match
// or the count limit, then gives the result; an out-of-range index skips the scan.
// Reset is synchronous and clears control and configuration; the store is not
// cleared. A search result waits in the finish state while the output is stalled.
module mirror_point_matcher #(
  parameter int MAX_POINTS = mpm_pkg::MAX_POINTS_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic                               cmd,
  input  logic [mpm_pkg::IDX_W-1:0]          point_index,
  input  logic signed [mpm_pkg::COORD_W-1:0] x_coord,
  input  logic signed [mpm_pkg::COORD_W-1:0] y_coord,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [mpm_pkg::IDX_W-1:0]          source_index,
  output logic [mpm_pkg::IDX_W-1:0]          mirror_index,
  output logic                               found,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [mpm_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [mpm_pkg::CFG_W-1:0]          cfg_data
);
  import mpm_pkg::*;

  mpm_cmd_t    cmd_bus;
  mpm_status_t st_bus;

  assign cfg_ready = 1'b1;

  mpm_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .cmd       (cmd),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .st        (st_bus),
    .cmd_o     (cmd_bus)
  );

  mpm_datapath #(
    .MAX_POINTS (MAX_POINTS)
  ) u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cfg_valid    (cfg_valid),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .point_index  (point_index),
    .x_coord      (x_coord),
    .y_coord      (y_coord),
    .cmd_i        (cmd_bus),
    .st           (st_bus),
    .source_index (source_index),
    .mirror_index (mirror_index),
    .found        (found)
  );

endmodule

### design/mpm_ram.sv
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with a registered read port.
// Stands alone; holds the point store of the matcher.
module mpm_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### design/mpm_ctrl.sv
`timescale 1ns / 1ps
// Controller for the mirror point matcher: sequences loads, searches and results.
// Depends on mpm_pkg for the command and status structs.
module mpm_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic                 cmd,
  output logic                 out_valid,
  input  logic                 out_ready,
  input  mpm_pkg::mpm_status_t st,
  output mpm_pkg::mpm_cmd_t    cmd_o
);
  import mpm_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_SRC  = 3'd1;
  localparam logic [2:0] S_SCAN = 3'd2;
  localparam logic [2:0] S_FIN  = 3'd3;

  logic [2:0] state;
  logic [2:0] state_next;
  logic       out_valid_next;
  logic       accept;

  assign in_ready = (state == S_IDLE);
  assign accept   = in_valid && in_ready;

  always_comb begin
    cmd_o      = '0;
    state_next = state;
    case (state)
      S_IDLE: begin
        if (accept) begin
          if (cmd == CMD_LOAD) begin
            cmd_o.ram_we = st.idx_ok;
          end else begin
            cmd_o.start = 1'b1;
            if (!st.idx_ok || st.limit_zero) begin
              state_next = S_FIN;
            end else begin
              cmd_o.rd_src = 1'b1;
              state_next   = S_SRC;
            end
          end
        end
      end
      S_SRC: begin
        cmd_o.latch_src = 1'b1;
        cmd_o.issue     = 1'b1;
        state_next      = S_SCAN;
      end
      S_SCAN: begin
        if (st.hit) begin
          cmd_o.set_hit = 1'b1;
          cmd_o.flush   = 1'b1;
          state_next    = S_FIN;
        end else if (st.issue_more) begin
          cmd_o.issue = 1'b1;
        end else if (!st.pipe_busy) begin
          state_next = S_FIN;
        end
      end
      S_FIN: begin
        if (!out_valid || out_ready) begin
          cmd_o.out_load = 1'b1;
          state_next     = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_comb begin
    if (cmd_o.out_load) begin
      out_valid_next = 1'b1;
    end else if (out_ready) begin
      out_valid_next = 1'b0;
    end else begin
      out_valid_next = out_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

  a_hit_ends_scan: assert property (@(posedge clk) disable iff (rst)
    (state == S_SCAN && st.hit) |=> (state == S_FIN))
    else $error("scan continued after a match");

  a_fin_waits_slot: assert property (@(posedge clk) disable iff (rst)
    (state == S_FIN && out_valid && !out_ready) |=> (state == S_FIN))
    else $error("result left while output slot was full");

  a_bad_index_short: assert property (@(posedge clk) disable iff (rst)
    (accept && cmd == CMD_SEARCH && !st.idx_ok) |=> (state == S_FIN))
    else $error("search with out-of-range index did not finish at once");

  a_out_from_fin: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> ($past(state) == S_FIN))
    else $error("result appeared outside the finish state");

endmodule

### design/mpm_datapath.sv
`timescale 1ns / 1ps
// Datapath of the mirror point matcher: configuration registers, point store,
// scan pipeline and result registers. Depends on mpm_pkg and mpm_ram.
module mpm_datapath #(
  parameter int MAX_POINTS = mpm_pkg::MAX_POINTS_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_valid,
  input  logic [mpm_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [mpm_pkg::CFG_W-1:0]          cfg_data,
  input  logic [mpm_pkg::IDX_W-1:0]          point_index,
  input  logic signed [mpm_pkg::COORD_W-1:0] x_coord,
  input  logic signed [mpm_pkg::COORD_W-1:0] y_coord,
  input  mpm_pkg::mpm_cmd_t                  cmd_i,
  output mpm_pkg::mpm_status_t               st,
  output logic [mpm_pkg::IDX_W-1:0]          source_index,
  output logic [mpm_pkg::IDX_W-1:0]          mirror_index,
  output logic                               found
);
  import mpm_pkg::*;

  localparam int AW = $clog2(MAX_POINTS);
  localparam logic [CNT_W-1:0] ScanMax =
    CNT_W'((MAX_POINTS < INDEX_SPAN) ? MAX_POINTS : INDEX_SPAN);

  logic [MODE_W-1:0] reflect_mode;
  logic [TOL_W-1:0]  match_tolerance;
  logic [CNT_W-1:0]  point_count;
  logic [CNT_W-1:0]  limit;

  logic [CNT_W-1:0]  cnt;
  logic [IDX_W-1:0]  src_idx;
  logic signed [COORD_W-1:0] xi;
  logic signed [COORD_W-1:0] yi;

  logic [2*COORD_W-1:0] rdata;
  logic [AW-1:0]        raddr;
  logic signed [COORD_W-1:0] rx;
  logic signed [COORD_W-1:0] ry;

  logic             p1_valid;
  logic [IDX_W-1:0] p1_idx;
  logic             p2_valid;
  logic [IDX_W-1:0] p2_idx;
  logic signed [COORD_W:0] dx;
  logic signed [COORD_W:0] dy;
  logic signed [COORD_W:0] dx_next;
  logic signed [COORD_W:0] dy_next;
  logic signed [COORD_W:0] tol_pos;
  logic signed [COORD_W:0] tol_neg;

  logic             res_found;
  logic [IDX_W-1:0] res_mirror;

  always_ff @(posedge clk) begin
    if (rst) begin
      reflect_mode    <= MODE_X;
      match_tolerance <= TOL_RESET;
      point_count     <= COUNT_RESET;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_REFLECT_MODE:    reflect_mode    <= cfg_data[MODE_W-1:0];
        REG_MATCH_TOLERANCE: match_tolerance <= cfg_data[TOL_W-1:0];
        REG_POINT_COUNT:     point_count     <= cfg_data[CNT_W-1:0];
        default: begin
        end
      endcase
    end
  end

  assign limit = (point_count > ScanMax) ? ScanMax : point_count;

  assign st.idx_ok     = ({1'b0, point_index} < ScanMax);
  assign st.limit_zero = (limit == '0);
  assign st.issue_more = (cnt < limit);
  assign st.pipe_busy  = p1_valid || p2_valid;

  assign raddr = cmd_i.rd_src ? AW'(point_index) : AW'(cnt);

  mpm_ram #(
    .WIDTH (2 * COORD_W),
    .DEPTH (MAX_POINTS)
  ) u_store (
    .clk   (clk),
    .we    (cmd_i.ram_we),
    .waddr (AW'(point_index)),
    .wdata ({x_coord, y_coord}),
    .raddr (raddr),
    .rdata (rdata)
  );

  assign rx = rdata[2*COORD_W-1:COORD_W];
  assign ry = rdata[COORD_W-1:0];

  always_comb begin
    if (reflect_mode == MODE_Y) begin
      dx_next = {xi[COORD_W-1], xi} - {rx[COORD_W-1], rx};
    end else begin
      dx_next = {xi[COORD_W-1], xi} + {rx[COORD_W-1], rx};
    end
    if (reflect_mode == MODE_X) begin
      dy_next = {yi[COORD_W-1], yi} - {ry[COORD_W-1], ry};
    end else begin
      dy_next = {yi[COORD_W-1], yi} + {ry[COORD_W-1], ry};
    end
  end

  assign tol_pos = $signed({2'b00, match_tolerance});
  assign tol_neg = -tol_pos;
  assign st.hit  = p2_valid && (dx < tol_pos) && (dx > tol_neg)
                   && (dy < tol_pos) && (dy > tol_neg);

  always_ff @(posedge clk) begin
    if (rst) begin
      p1_valid <= 1'b0;
      p2_valid <= 1'b0;
    end else begin
      p1_valid <= cmd_i.issue;
      p2_valid <= p1_valid && !cmd_i.flush;
    end
  end

  always_ff @(posedge clk) begin
    p1_idx <= IDX_W'(cnt);
    p2_idx <= p1_idx;
    dx     <= dx_next;
    dy     <= dy_next;
    if (cmd_i.start) begin
      cnt        <= '0;
      src_idx    <= point_index;
      res_found  <= 1'b0;
      res_mirror <= '0;
    end else begin
      if (cmd_i.issue) begin
        cnt <= cnt + 1'b1;
      end
      if (cmd_i.set_hit) begin
        res_found  <= 1'b1;
        res_mirror <= p2_idx;
      end
    end
    if (cmd_i.latch_src) begin
      xi <= rx;
      yi <= ry;
    end
    if (cmd_i.out_load) begin
      source_index <= src_idx;
      mirror_index <= res_mirror;
      found        <= res_found;
    end
  end

endmodule
